[hw/rtl/mrc_pkg.sv]
// Shared types, constants and helper functions of the memory region coalescer.
package mrc_pkg;

    localparam int unsigned ADDR_W = 64;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IMAGE_BASE   = 3'd0;
    localparam logic [2:0] CFG_IMAGE_END    = 3'd1;
    localparam logic [2:0] CFG_ARENA_BASE   = 3'd2;
    localparam logic [2:0] CFG_ARENA_LENGTH = 3'd3;
    localparam logic [2:0] CFG_HIGHMEM      = 3'd4;
    localparam logic [2:0] CFG_CRUMB_MIN    = 3'd5;

    localparam logic [ADDR_W-1:0] HIGHMEM_RESET = 64'h0000_0000_0010_0000;
    localparam logic [ADDR_W-1:0] CRUMB_RESET   = 64'h0000_0000_0010_0000;

    // Output row kinds.
    localparam logic [1:0] KIND_KERNEL  = 2'd0;
    localparam logic [1:0] KIND_LOWMEM  = 2'd1;
    localparam logic [1:0] KIND_HIGHMEM = 2'd2;
    localparam logic [1:0] KIND_ARENA   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] image_base;
        logic [ADDR_W-1:0] image_end;
        logic [ADDR_W-1:0] arena_start;
        logic [ADDR_W-1:0] arena_length;
        logic [ADDR_W-1:0] lowmem_limit;
        logic [ADDR_W-1:0] crumb_min_length;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } span_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_WR,
        ST_KERN,
        ST_MRG_RD,
        ST_MRG_CMP,
        ST_FLUSH,
        ST_HIGH,
        ST_ARENA
    } state_t;

    // Exact overlap test of two half-open spans, with no wrap past the top.
    function automatic logic spans_meet(input logic [ADDR_W-1:0] a,
                                        input logic [ADDR_W-1:0] alen,
                                        input logic [ADDR_W-1:0] b,
                                        input logic [ADDR_W-1:0] blen);
        logic r;
        if (alen == '0 || blen == '0) begin
            r = 1'b0;
        end else if (a >= b) begin
            r = (a - b) < blen;
        end else begin
            r = (b - a) < alen;
        end
        return r;
    endfunction

    // Sum that sticks at all ones on overflow.
    function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ADDR_W] ? {ADDR_W{1'b1}} : s[ADDR_W-1:0];
    endfunction

endpackage

[hw/rtl/memory_region_coalescer.sv]
// Memory region coalescer: sorted span store, merge pass and row emission.
// A dropped word only passes the filter; a kept word is written straight into an empty store,
// else each larger stored span is shifted up one entry before the word is written below them.
// The last word then starts the kernel row, merge pass, high-memory and arena rows; stalls apply.
// The input takes one word at a time: s_ready is high only while idle.
// Reset clears control state and span count and loads register resets, not the span memory.
module memory_region_coalescer import mrc_pkg::*; #(
    parameter int unsigned MAX_SPANS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ADDR_W-1:0] s_region_base,
    input  logic [ADDR_W-1:0] s_region_length,
    input  logic              s_is_available,
    input  logic              s_last_region,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_row_kind,
    output logic [ADDR_W-1:0] m_row_base,
    output logic [ADDR_W-1:0] m_row_length,
    output logic              m_last_row,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_wdata
);

    localparam int unsigned CW = $clog2(MAX_SPANS + 1);
    localparam int unsigned AW = $clog2(MAX_SPANS);

    state_t state_reg, state_next;
    cfg_t   cfg_reg;

    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [ADDR_W-1:0] base_reg, len_reg;
    logic              avail_reg, last_reg;

    logic [ADDR_W-1:0] cur_start_reg, cur_start_next;
    logic [ADDR_W-1:0] cur_size_reg, cur_size_next;
    logic              have_cur_reg, have_cur_next;
    logic [ADDR_W-1:0] hi_base_reg, hi_base_next;
    logic [ADDR_W-1:0] hi_len_reg, hi_len_next;
    logic              have_hi_reg, have_hi_next;

    logic              m_valid_reg;
    logic [1:0]        m_kind_reg;
    logic [ADDR_W-1:0] m_base_reg, m_len_reg;
    logic              m_last_reg;

    logic              emit;
    logic [1:0]        emit_kind;
    logic [ADDR_W-1:0] emit_base, emit_len;
    logic              emit_last;
    logic              out_free;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    span_t             wr_data, rd_data;

    logic              keep;
    logic              kernel_ok;
    logic              cur_low;
    logic [ADDR_W-1:0] gap;
    logic [CW-1:0]     idx_inc;

    mrc_span_mem #(.DEPTH(MAX_SPANS), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mrc_filter u_filter (
        .cfg    (cfg_reg),
        .base   (base_reg),
        .length (len_reg),
        .avail  (avail_reg),
        .keep   (keep)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_base       <= '0;
            cfg_reg.image_end        <= '0;
            cfg_reg.arena_start      <= '0;
            cfg_reg.arena_length     <= '0;
            cfg_reg.lowmem_limit     <= HIGHMEM_RESET;
            cfg_reg.crumb_min_length <= CRUMB_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_BASE:   cfg_reg.image_base       <= cfg_wdata;
                CFG_IMAGE_END:    cfg_reg.image_end        <= cfg_wdata;
                CFG_ARENA_BASE:   cfg_reg.arena_start      <= cfg_wdata;
                CFG_ARENA_LENGTH: cfg_reg.arena_length     <= cfg_wdata;
                CFG_HIGHMEM:      cfg_reg.lowmem_limit     <= cfg_wdata;
                CFG_CRUMB_MIN:    cfg_reg.crumb_min_length <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input word capture.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            base_reg  <= s_region_base;
            len_reg   <= s_region_length;
            avail_reg <= s_is_available;
            last_reg  <= s_last_region;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            have_cur_reg <= 1'b0;
            have_hi_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            have_cur_reg <= have_cur_next;
            have_hi_reg  <= have_hi_next;
        end
    end

    // Working registers of the insert and merge passes.
    always_ff @(posedge aclk) begin
        j_reg         <= j_next;
        idx_reg       <= idx_next;
        cur_start_reg <= cur_start_next;
        cur_size_reg  <= cur_size_next;
        hi_base_reg   <= hi_base_next;
        hi_len_reg    <= hi_len_next;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_kind_reg <= emit_kind;
            m_base_reg <= emit_base;
            m_len_reg  <= emit_len;
            m_last_reg <= emit_last;
        end
    end

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_row_kind   = m_kind_reg;
    assign m_row_base   = m_base_reg;
    assign m_row_length = m_len_reg;
    assign m_last_row   = m_last_reg;

    assign kernel_ok = (cfg_reg.image_base != '0) && (cfg_reg.image_end > cfg_reg.image_base);
    assign cur_low   = cur_start_reg < cfg_reg.lowmem_limit;
    assign gap       = rd_data.start - cur_start_reg;
    assign idx_inc   = idx_reg + CW'(1);

    // Next state, memory access and row emission.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        idx_next       = idx_reg;
        cur_start_next = cur_start_reg;
        cur_size_next  = cur_size_reg;
        have_cur_next  = have_cur_reg;
        hi_base_next   = hi_base_reg;
        hi_len_next    = hi_len_reg;
        have_hi_next   = have_hi_reg;

        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = '{start: base_reg, size: len_reg};
        rd_en   = 1'b0;
        rd_addr = j_reg - AW'(1);

        emit      = 1'b0;
        emit_kind = KIND_LOWMEM;
        emit_base = cur_start_reg;
        emit_len  = cur_size_reg;
        emit_last = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FILT;
                end
            end

            // Decide whether to store the word, and where the insert starts.
            ST_FILT: begin
                j_next = count_reg[AW-1:0];
                if (!keep || count_reg == CW'(MAX_SPANS)) begin
                    state_next = last_reg ? ST_KERN : ST_IDLE;
                end else if (count_reg == '0) begin
                    state_next = ST_INS_WR;
                end else begin
                    state_next = ST_INS_RD;
                end
            end

            ST_INS_RD: begin
                rd_en      = 1'b1;
                state_next = ST_INS_CMP;
            end

            // Shift a larger neighbor up, or drop the new span in its place.
            ST_INS_CMP: begin
                wr_en = 1'b1;
                if (rd_data.start > base_reg) begin
                    wr_data    = rd_data;
                    j_next     = j_reg - AW'(1);
                    state_next = (j_reg == AW'(1)) ? ST_INS_WR : ST_INS_RD;
                end else begin
                    count_next = count_reg + CW'(1);
                    state_next = last_reg ? ST_KERN : ST_IDLE;
                end
            end

            ST_INS_WR: begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = last_reg ? ST_KERN : ST_IDLE;
            end

            // Kernel row if the image is set, then the merge pass, or the high-memory row if the store is empty.
            ST_KERN: begin
                if (!kernel_ok || out_free) begin
                    emit          = kernel_ok;
                    emit_kind     = KIND_KERNEL;
                    emit_base     = cfg_reg.image_base;
                    emit_len      = cfg_reg.image_end - cfg_reg.image_base;
                    idx_next      = '0;
                    have_cur_next = 1'b0;
                    have_hi_next  = 1'b0;
                    hi_len_next   = '0;
                    state_next    = (count_reg == '0) ? ST_HIGH : ST_MRG_RD;
                end
            end

            ST_MRG_RD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg[AW-1:0];
                state_next = ST_MRG_CMP;
            end

            // Fold the span just read into the open span, or close the open one.
            ST_MRG_CMP: begin
                if (!have_cur_reg || gap <= cur_size_reg) begin
                    if (!have_cur_reg) begin
                        cur_start_next = rd_data.start;
                        cur_size_next  = rd_data.size;
                        have_cur_next  = 1'b1;
                    end else if (rd_data.size > cur_size_reg - gap) begin
                        cur_size_next = sat_add(gap, rd_data.size);
                    end
                    idx_next   = idx_inc;
                    state_next = (idx_inc == count_reg) ? ST_FLUSH : ST_MRG_RD;
                end else if (!cur_low || out_free) begin
                    emit = cur_low;
                    if (!cur_low) begin
                        if (!have_hi_reg) begin
                            hi_base_next = cur_start_reg;
                        end
                        hi_len_next  = sat_add(hi_len_reg, cur_size_reg);
                        have_hi_next = 1'b1;
                    end
                    cur_start_next = rd_data.start;
                    cur_size_next  = rd_data.size;
                    idx_next       = idx_inc;
                    state_next     = (idx_inc == count_reg) ? ST_FLUSH : ST_MRG_RD;
                end
            end

            // Close the last open span.
            ST_FLUSH: begin
                if (!cur_low || out_free) begin
                    emit = cur_low;
                    if (!cur_low) begin
                        if (!have_hi_reg) begin
                            hi_base_next = cur_start_reg;
                        end
                        hi_len_next  = sat_add(hi_len_reg, cur_size_reg);
                        have_hi_next = 1'b1;
                    end
                    state_next = ST_HIGH;
                end
            end

            ST_HIGH: begin
                if (!have_hi_reg || out_free) begin
                    emit       = have_hi_reg;
                    emit_kind  = KIND_HIGHMEM;
                    emit_base  = hi_base_reg;
                    emit_len   = hi_len_reg;
                    state_next = ST_ARENA;
                end
            end

            // Arena row closes the run and empties the store.
            ST_ARENA: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_ARENA;
                    emit_base  = cfg_reg.arena_start;
                    emit_len   = cfg_reg.arena_length;
                    emit_last  = 1'b1;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The store never holds more spans than it has entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_SPANS))
        else $error("span count above store depth");

    // Only the arena row carries the last-row flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_row |-> m_row_kind == KIND_ARENA)
        else $error("last row flag on a non-arena row");

    // Loading the closing row leaves the store empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit && emit_last |=> count_reg == '0)
        else $error("store not emptied after the run");

    // A new row is never loaded over one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("output register overwritten");

endmodule

[hw/rtl/mrc_span_mem.sv]
// Span store: one write port and one read port with registered read data.
module mrc_span_mem import mrc_pkg::*; #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  span_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output span_t         rd_data
);

    span_t mem [DEPTH];
    span_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/mrc_filter.sv]
// Keep test of one incoming region: available, nonzero length, and clear of the image, arena and crumb rules.
module mrc_filter import mrc_pkg::*; (
    input  cfg_t              cfg,
    input  logic [ADDR_W-1:0] base,
    input  logic [ADDR_W-1:0] length,
    input  logic              avail,
    output logic              keep
);

    logic image_ok;
    logic hit_image;
    logic hit_arena;
    logic crumb;

    // Each rule is evaluated in parallel and combined at the end.
    always_comb begin
        image_ok  = cfg.image_end > cfg.image_base;
        hit_image = image_ok &&
                    spans_meet(base, length, cfg.image_base, cfg.image_end - cfg.image_base);
        hit_arena = (cfg.arena_length != '0) &&
                    spans_meet(base, length, cfg.arena_start, cfg.arena_length);
        crumb     = (base >= cfg.lowmem_limit) && (length < cfg.crumb_min_length);
        keep      = avail && (length != '0) && !hit_image && !hit_arena && !crumb;
    end

endmodule
